>>> sv/rotation_matrix_to_euler_macros.svh
// Assertion macros for the rotation matrix to Euler angle block.
// Used by the checker only; expects clk_i and rst_ni in scope.
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// same-cycle implication
`define RME_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rme assertion failed");

// next-cycle implication
`define RME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rme assertion failed");

`endif

>>> sv/rme_pkg.sv
// Shared types, constants and the arctangent table for the Euler block.
// No dependencies.
`default_nettype none
package rme_pkg;

  localparam int unsigned SQRT_STEPS = 15;
  localparam int unsigned REG_GIMBAL_THRESHOLD = 0;
  localparam logic [14:0] THRESH_RESET = 15'd82;
  localparam logic signed [23:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [23:0] PI_Q12_W = 24'sd12868;
  localparam logic signed [15:0] PI_Q12 = 16'sd12868;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam int unsigned LANE_ROLL = 0;
  localparam int unsigned LANE_PITCH = 1;
  localparam int unsigned LANE_YAW = 2;

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic        e0_pos;
  } side_t;

  // square root cell payload
  typedef struct packed {
    logic [29:0]        n;
    logic [29:0]        res;
    logic signed [15:0] s;
    logic signed [15:0] e0;
    logic signed [15:0] e1;
    logic signed [15:0] e4;
    logic signed [15:0] e5;
    logic signed [15:0] e9;
    logic signed [15:0] e10;
    side_t              side;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [23:0] z;
    logic               zero;
  } lane_t;

  // CORDIC cell payload: three lanes share the chain
  typedef struct packed {
    lane_t [2:0] lane;
    side_t       side;
    logic        lock;
  } cord_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic signed [23:0] atan_entry(input int unsigned i);
    logic signed [23:0] v;
    case (i)
      0: v = 24'sd823550;
      1: v = 24'sd486170;
      2: v = 24'sd256879;
      3: v = 24'sd130396;
      4: v = 24'sd65451;
      5: v = 24'sd32757;
      6: v = 24'sd16383;
      7: v = 24'sd8192;
      8: v = 24'sd4096;
      9: v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/rme_if.sv
// Valid/ready channel interfaces for pose input and angle output.
// No dependencies.
`default_nettype none
interface rme_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] entry_0;
  logic signed [15:0] entry_1;
  logic signed [15:0] entry_4;
  logic signed [15:0] entry_5;
  logic signed [15:0] entry_8;
  logic signed [15:0] entry_9;
  logic signed [15:0] entry_10;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  modport source (output valid, entry_0, entry_1, entry_4, entry_5, entry_8, entry_9,
                  entry_10, trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, entry_0, entry_1, entry_4, entry_5, entry_8, entry_9,
                entry_10, trans_x, trans_y, trans_z, output ready);
endinterface

interface rme_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll;
  logic signed [15:0] pitch;
  logic signed [14:0] yaw;
  logic               gimbal_lock;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, roll, pitch, yaw, gimbal_lock, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, roll, pitch, yaw, gimbal_lock, pos_x, pos_y, pos_z,
                output ready);
endinterface
`default_nettype wire

>>> sv/rotation_matrix_to_euler.sv
// Throughput: one pose per cycle; the whole chain advances unless the output is stalled.
// Chain: square step, 15 square-root cells, argument setup, CORDIC_STEPS CORDIC cells,
// rounding/output register. Reset clears all valid bits and sets threshold to 82.
// Depends on rme_pkg, rme_if, rme_sqrt_cell, rme_cordic_cell.
`default_nettype none
module rotation_matrix_to_euler #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rme_in_if.sink           in_s,
  rme_out_if.source        out_m,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned NSq = rme_pkg::SQRT_STEPS;

  logic adv;
  logic [14:0] thresh_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= rme_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite
                 && (paddr[2] == 1'(rme_pkg::REG_GIMBAL_THRESHOLD))) begin
      thresh_q <= pwdata[14:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(rme_pkg::REG_GIMBAL_THRESHOLD)) ? {17'd0, thresh_q} : 32'd0;

  // global advance: hold everything while the output waits
  assign adv = !out_m.valid || out_m.ready;
  assign in_s.ready = adv;

  // square step: saturate sine, form 2^28 - s^2
  logic signed [15:0] s_sat;
  logic signed [31:0] s_sq;
  rme_pkg::sqrt_t sq_d;
  logic sq_v [NSq + 1];
  rme_pkg::sqrt_t sq_q [NSq + 1];

  always_comb begin
    if (in_s.entry_8 > rme_pkg::ONE_Q14) begin
      s_sat = rme_pkg::ONE_Q14;
    end else if (in_s.entry_8 < -rme_pkg::ONE_Q14) begin
      s_sat = -rme_pkg::ONE_Q14;
    end else begin
      s_sat = in_s.entry_8;
    end
    s_sq = s_sat * s_sat;
    sq_d.n = 30'(1) << 28;
    sq_d.n = sq_d.n - s_sq[29:0];
    sq_d.res = '0;
    sq_d.s = s_sat;
    sq_d.e0 = in_s.entry_0;
    sq_d.e1 = in_s.entry_1;
    sq_d.e4 = in_s.entry_4;
    sq_d.e5 = in_s.entry_5;
    sq_d.e9 = in_s.entry_9;
    sq_d.e10 = in_s.entry_10;
    sq_d.side.tx = in_s.trans_x;
    sq_d.side.ty = in_s.trans_y;
    sq_d.side.tz = in_s.trans_z;
    sq_d.side.e0_pos = (in_s.entry_0 > 16'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_d;
    end
  end

  // square-root chain, most significant digit first
  for (genvar j = 0; j < NSq; j++) begin : g_sqrt
    rme_sqrt_cell #(.K(NSq - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_v[j]),
      .data_i  (sq_q[j]),
      .valid_o (sq_v[j + 1]),
      .data_o  (sq_q[j + 1])
    );
  end

  // atan2 argument setup with rotation by pi for negative x
  function automatic rme_pkg::lane_t make_lane(input logic signed [16:0] y,
                                               input logic signed [16:0] x);
    rme_pkg::lane_t l;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = 34'(x) <<< 14;
    ys = 34'(y) <<< 14;
    l.zero = (x == 17'sd0) && (y == 17'sd0);
    if (x < 17'sd0) begin
      l.z = y[16] ? -rme_pkg::PI_Q20 : rme_pkg::PI_Q20;
      l.x = -xs;
      l.y = -ys;
    end else begin
      l.z = '0;
      l.x = xs;
      l.y = ys;
    end
    return l;
  endfunction

  rme_pkg::sqrt_t sqf;
  logic [14:0] cmag;
  logic lock;
  logic signed [16:0] e0w, e1w, e4w, e5w, e9w, e10w;
  rme_pkg::cord_t cd_d;
  logic cd_v [CORDIC_STEPS + 1];
  rme_pkg::cord_t cd_q [CORDIC_STEPS + 1];

  always_comb begin
    sqf = sq_q[NSq];
    cmag = sqf.res[14:0];
    lock = (cmag <= thresh_q);
    e0w = 17'(sqf.e0);
    e1w = 17'(sqf.e1);
    e4w = 17'(sqf.e4);
    e5w = 17'(sqf.e5);
    e9w = 17'(sqf.e9);
    e10w = 17'(sqf.e10);
    cd_d.side = sqf.side;
    cd_d.lock = lock;
    cd_d.lane[rme_pkg::LANE_PITCH] = make_lane(17'(sqf.s), {2'b00, cmag});
    if (sqf.side.e0_pos) begin
      cd_d.lane[rme_pkg::LANE_ROLL] = make_lane(-e9w, e10w);
    end else begin
      cd_d.lane[rme_pkg::LANE_ROLL] = make_lane(e9w, -e10w);
    end
    if (lock) begin
      cd_d.lane[rme_pkg::LANE_YAW] = make_lane(e1w, e5w);
    end else if (sqf.side.e0_pos) begin
      cd_d.lane[rme_pkg::LANE_YAW] = make_lane(-e4w, e0w);
    end else begin
      cd_d.lane[rme_pkg::LANE_YAW] = make_lane(e4w, -e0w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_v[0] <= 1'b0;
    end else if (adv) begin
      cd_v[0] <= sq_v[NSq];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cd_q[0] <= cd_d;
    end
  end

  // CORDIC chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rme_cordic_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (cd_v[i]),
      .data_i  (cd_q[i]),
      .valid_o (cd_v[i + 1]),
      .data_o  (cd_q[i + 1])
    );
  end

  // round to Q4.12 and clamp
  function automatic logic signed [15:0] finish(input rme_pkg::lane_t l);
    logic signed [23:0] r;
    logic signed [15:0] v;
    r = (l.z + 24'sd128) >>> 8;
    if (l.zero) begin
      v = '0;
    end else if (r > rme_pkg::PI_Q12_W) begin
      v = rme_pkg::PI_Q12;
    end else if (r < -rme_pkg::PI_Q12_W) begin
      v = -rme_pkg::PI_Q12;
    end else begin
      v = r[15:0];
    end
    return v;
  endfunction

  rme_pkg::cord_t cf;
  logic signed [15:0] roll_a, pitch_a, yaw_a, pitch_d;

  always_comb begin
    cf = cd_q[CORDIC_STEPS];
    roll_a = finish(cf.lane[rme_pkg::LANE_ROLL]);
    pitch_a = finish(cf.lane[rme_pkg::LANE_PITCH]);
    yaw_a = finish(cf.lane[rme_pkg::LANE_YAW]);
    pitch_d = cf.side.e0_pos ? pitch_a : (rme_pkg::PI_Q12 - pitch_a);
  end

  // output register
  logic out_valid_q;
  logic signed [14:0] roll_q, yaw_q;
  logic signed [15:0] pitch_q;
  logic lock_q;
  logic [31:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q <= cf.lock ? 15'sd0 : roll_a[14:0];
      pitch_q <= pitch_d;
      yaw_q <= yaw_a[14:0];
      lock_q <= cf.lock;
      px_q <= cf.side.tx;
      py_q <= cf.side.ty;
      pz_q <= cf.side.tz;
    end
  end

  assign out_m.valid = out_valid_q;
  assign out_m.roll = roll_q;
  assign out_m.pitch = pitch_q;
  assign out_m.yaw = yaw_q;
  assign out_m.gimbal_lock = lock_q;
  assign out_m.pos_x = px_q;
  assign out_m.pos_y = py_q;
  assign out_m.pos_z = pz_q;
endmodule
`default_nettype wire

>>> sv/rme_sqrt_cell.sv
// One digit of the integer square root (one result bit per cell).
// Depends on rme_pkg.
`default_nettype none
module rme_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire rme_pkg::sqrt_t data_i,
  output logic               valid_o,
  output rme_pkg::sqrt_t     data_o
);
  localparam logic [29:0] BitVal = 30'(1) << (2 * K);

  rme_pkg::sqrt_t data_d, data_q;
  logic valid_q;
  logic [29:0] trial;

  // compare and subtract for this digit
  always_comb begin
    data_d = data_i;
    trial = data_i.res + BitVal;
    if (data_i.n >= trial) begin
      data_d.n = data_i.n - trial;
      data_d.res = (data_i.res >> 1) + BitVal;
    end else begin
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

>>> sv/rme_cordic_cell.sv
// One vectoring CORDIC micro-rotation applied to all three angle lanes.
// Depends on rme_pkg.
`default_nettype none
module rme_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire rme_pkg::cord_t data_i,
  output logic               valid_o,
  output rme_pkg::cord_t     data_o
);
  localparam logic signed [23:0] Angle = rme_pkg::atan_entry(STEP);

  rme_pkg::cord_t data_d, data_q;
  logic valid_q;

  // drive y towards zero on every lane
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      if (!data_i.lane[l].y[33]) begin
        data_d.lane[l].x = data_i.lane[l].x + (data_i.lane[l].y >>> STEP);
        data_d.lane[l].y = data_i.lane[l].y - (data_i.lane[l].x >>> STEP);
        data_d.lane[l].z = data_i.lane[l].z + Angle;
      end else begin
        data_d.lane[l].x = data_i.lane[l].x - (data_i.lane[l].y >>> STEP);
        data_d.lane[l].y = data_i.lane[l].y + (data_i.lane[l].x >>> STEP);
        data_d.lane[l].z = data_i.lane[l].z - Angle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

>>> sv/rme_checker.sv
// Port-level checks for the Euler block, bound to the top level.
// Depends on rotation_matrix_to_euler_macros.svh and rotation_matrix_to_euler.
`default_nettype none
`include "rotation_matrix_to_euler_macros.svh"
module rme_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [14:0] roll,
  input wire logic signed [15:0] pitch,
  input wire logic signed [14:0] yaw,
  input wire logic               gimbal_lock
);
  // a stalled result stays offered
  `RME_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
  // roll is forced to zero in gimbal lock
  `RME_ASSERT_IMP(a_lock_roll, out_valid && gimbal_lock, roll == 15'sd0)
  // pitch stays within -pi/2 .. 3pi/2
  `RME_ASSERT_IMP(a_pitch, out_valid, pitch >= -16'sd6434 && pitch <= 16'sd19302)
  // yaw clamped to +-pi
  `RME_ASSERT_IMP(a_yaw, out_valid, yaw >= -15'sd12868 && yaw <= 15'sd12868)
endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_m.valid),
  .out_ready   (out_m.ready),
  .roll        (out_m.roll),
  .pitch       (out_m.pitch),
  .yaw         (out_m.yaw),
  .gimbal_lock (out_m.gimbal_lock)
);
`default_nettype wire
